// ----- design/tcw_pkg.sv -----
// shared types and constants for the text console writer
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int RADDR_W = 11;
   localparam int CIDX_W  = 11;
   localparam int CCOL_W  = 7;
   localparam int CROW_W  = 5;
   localparam int CELL_W  = 16;
   localparam int ATTR_W  = 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

endpackage

// ----- design/tcw_req_if.sv -----
// request channel: operation, character and read address
`timescale 1ns / 1ps
interface tcw_req_if;
   import tcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [CHAR_W-1:0]  character;
   logic [RADDR_W-1:0] read_address;

   modport source (output valid, operation, character, read_address, input ready);
   modport sink   (input valid, operation, character, read_address, output ready);
endinterface

// ----- design/tcw_rsp_if.sv -----
// response channel: cursor position, read data and scroll flag
`timescale 1ns / 1ps
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CIDX_W-1:0] cursor_index;
   logic [CCOL_W-1:0] cursor_column;
   logic [CROW_W-1:0] cursor_row;
   logic [CELL_W-1:0] read_data;
   logic              scrolled;

   modport source (output valid, cursor_index, cursor_column, cursor_row, read_data, scrolled,
                   input ready);
   modport sink   (input valid, cursor_index, cursor_column, cursor_row, read_data, scrolled,
                   output ready);
endinterface

// ----- design/text_console_writer.sv -----
// text console writer: screen store, cursor and sequencer for put, clear and read
// put character: the result is registered through the done state; a scroll first walks copy then fill
// clear: a fill walk over every cell; read: read then done state; one item in flight, ready only when idle
// scroll and clear walk the screen store, one cell per cycle on its one write port
// reset: synchronous, clears cursor and sets attribute to ATTR_RESET, then a blanking pass over
// every cell during which no item is accepted; csr writes are taken throughout
`timescale 1ns / 1ps
module text_console_writer #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   tcw_req_if.sink                   req_bus,
   tcw_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_write_data
);
   import tcw_pkg::*;

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int PH_W    = $clog2(TAB_STOP);
   localparam int NCOL_W  = $clog2(COLUMNS + TAB_STOP);
   localparam int NROW_W  = $clog2(ROWS + 1);

   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SHIFT_END  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, SPACE_CHAR};

   typedef enum logic [5:0] {
      S_INIT = 6'b000001,
      S_IDLE = 6'b000010,
      S_READ = 6'b000100,
      S_COPY = 6'b001000,
      S_FILL = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  dst_ff, dst_in;
   logic               copy_ff, copy_in;
   logic [CELL_W-1:0]  blank_ff, blank_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [CELL_W-1:0]  res_data_ff, res_data_in;
   logic               res_scr_ff, res_scr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CIDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [CCOL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_scr_ff, rsp_scr_in;

   logic [ADDR_W-1:0]  cur_idx;
   logic [NCOL_W-1:0]  ncol;
   logic [NROW_W-1:0]  nrow;
   logic [PH_W-1:0]    nph;
   logic               wr_cell;
   logic               need_scroll;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cur_idx = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_ff);

   // cursor update for put character; phase tracks column mod tab stop
   always_comb begin
      ncol    = NCOL_W'(col_ff);
      nrow    = NROW_W'(row_ff);
      nph     = phase_ff;
      wr_cell = 1'b0;
      if (req_bus.character == CHAR_BS) begin
         if (col_ff != '0) begin
            ncol = NCOL_W'(col_ff) - NCOL_W'(1);
            nph  = (phase_ff == '0) ? PH_W'(TAB_STOP - 1) : phase_ff - PH_W'(1);
         end
      end else if (req_bus.character == CHAR_TAB) begin
         ncol = NCOL_W'(col_ff) + NCOL_W'(TAB_STOP) - NCOL_W'(phase_ff);
         nph  = '0;
      end else if (req_bus.character == CHAR_CR) begin
         ncol = '0;
         nph  = '0;
      end else if (req_bus.character == CHAR_LF) begin
         ncol = '0;
         nph  = '0;
         nrow = nrow + NROW_W'(1);
      end else if (req_bus.character >= SPACE_CHAR) begin
         wr_cell = 1'b1;
         ncol    = ncol + NCOL_W'(1);
         nph     = (phase_ff == PH_W'(TAB_STOP - 1)) ? '0 : phase_ff + PH_W'(1);
      end
      // right edge wraps
      if (ncol >= NCOL_W'(COLUMNS)) begin
         ncol = '0;
         nph  = '0;
         nrow = nrow + NROW_W'(1);
      end
      need_scroll = (nrow >= NROW_W'(ROWS));
      if (need_scroll) begin
         nrow = NROW_W'(ROWS - 1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      dst_in       = dst_ff;
      copy_in      = copy_ff;
      blank_in     = blank_ff;
      rd_ok_in     = rd_ok_ff;
      res_data_in  = res_data_ff;
      res_scr_in   = res_scr_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_scr_in   = rsp_scr_ff;
      attr_in      = csr_write_enable ? csr_write_data : attr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = blank_ff;
      ram_raddr    = cnt_ff + COLS_A;

      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_CELL;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               res_scr_in  = 1'b0;
               res_data_in = '0;
               case (req_bus.operation)
                  OP_PUT: begin
                     ram_we    = wr_cell;
                     ram_waddr = cur_idx;
                     ram_wdata = {attr_ff, req_bus.character};
                     col_in    = COL_W'(ncol);
                     row_in    = ROW_W'(nrow);
                     phase_in  = nph;
                     if (need_scroll) begin
                        res_scr_in = 1'b1;
                        blank_in   = {attr_ff, SPACE_CHAR};
                        cnt_in     = '0;
                        copy_in    = 1'b0;
                        state_in   = S_COPY;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                     blank_in = {attr_ff, SPACE_CHAR};
                     cnt_in   = '0;
                     state_in = S_FILL;
                  end
                  OP_READ: begin
                     ram_raddr = ADDR_W'(req_bus.read_address);
                     rd_ok_in  = (32'(req_bus.read_address) < 32'(CELLS));
                     state_in  = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_data_in = rd_ok_ff ? ram_rdata : '0;
            state_in    = S_DONE;
         end
         S_COPY: begin
            // read one row ahead, write the beat back in the next cycle
            copy_in   = (cnt_ff < SHIFT_END);
            dst_in    = cnt_ff;
            ram_we    = copy_ff;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            if (cnt_ff == SHIFT_END) begin
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_FILL: begin
            ram_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = CIDX_W'(cur_idx);
               rsp_col_in   = CCOL_W'(col_ff);
               rsp_row_in   = CROW_W'(row_ff);
               rsp_data_in  = res_data_ff;
               rsp_scr_in   = res_scr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         attr_ff      <= ATTR_RESET;
         cnt_ff       <= '0;
         copy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         attr_ff      <= attr_in;
         cnt_ff       <= cnt_in;
         copy_ff      <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dst_ff      <= dst_in;
      blank_ff    <= blank_in;
      rd_ok_ff    <= rd_ok_in;
      res_data_ff <= res_data_in;
      res_scr_ff  <= res_scr_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cursor_index  = rsp_idx_ff;
   assign rsp_bus.cursor_column = rsp_col_ff;
   assign rsp_bus.cursor_row    = rsp_row_ff;
   assign rsp_bus.read_data     = rsp_data_ff;
   assign rsp_bus.scrolled      = rsp_scr_ff;
endmodule

// ----- design/tcw_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/tcw_chk.sv -----
// port-level checker for the text console writer, bound to the top level
`timescale 1ns / 1ps
module tcw_chk #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tcw_pkg::CIDX_W-1:0]  cursor_index,
   input logic [tcw_pkg::CCOL_W-1:0]  cursor_column,
   input logic [tcw_pkg::CROW_W-1:0]  cursor_row,
   input logic [tcw_pkg::CELL_W-1:0]  read_data,
   input logic                        scrolled
);
   import tcw_pkg::*;

   // a response beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_index) && $stable(read_data)
         && $stable(scrolled))
      else $error("response beat changed while stalled");

   // reset starts the blanking pass: no beats either way
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   // one item in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a beat while busy");

   a_index_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cursor_index == CIDX_W'(32'(cursor_row) * COLUMNS + 32'(cursor_column)))
      else $error("cursor index disagrees with row and column");

   // a scroll leaves the cursor on the bottom row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && scrolled |-> cursor_row == CROW_W'(ROWS - 1))
      else $error("scroll without cursor on bottom row");
endmodule

bind text_console_writer tcw_chk #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .cursor_index  (rsp_bus.cursor_index),
   .cursor_column (rsp_bus.cursor_column),
   .cursor_row    (rsp_bus.cursor_row),
   .read_data     (rsp_bus.read_data),
   .scrolled      (rsp_bus.scrolled)
);
